// ===== rtl/integer_partition_counter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the integer partition counter
// Shorthand for clocked, reset-qualified assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef INTEGER_PARTITION_COUNTER_UNIT_MACROS_SVH
`define INTEGER_PARTITION_COUNTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ipc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared constants, types, helper functions and the control store of the
// integer partition counter.
// ----------------------------------------------------------------------------
package ipc_pkg;

  localparam int MAX_N       = 127;
  localparam int ROW_LEN     = MAX_N + 1;
  localparam int TABLE_DEPTH = ROW_LEN * ROW_LEN;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int QW          = 7;
  localparam int DW          = 64;
  localparam int CW_RAW      = $clog2(MAX_N + 2);
  localparam int CW          = (CW_RAW > QW) ? CW_RAW : QW;
  localparam int PW          = 4;

  localparam logic [DW-1:0] ALL_ONES = '1;

  typedef logic [CW-1:0] cnt_t;
  typedef logic [AW-1:0] addr_t;
  typedef logic [DW-1:0] word_t;
  typedef logic [PW-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_CHKN,
    OP_ROWCHK,
    OP_KCHK,
    OP_KSET,
    OP_SUM,
    OP_WRITE,
    OP_RSINIT,
    OP_PART,
    OP_DONE
  } ipc_op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_FIRE,
    C_BAD_N,
    C_ROW_PAST,
    C_K_PAST,
    C_K_EDGE,
    C_LAST,
    C_OUT_FREE
  } ipc_cond_t;

  // One control word: datapath operation, branch condition, branch target,
  // and whether a false condition holds the step instead of advancing.
  typedef struct packed {
    ipc_op_t   op;
    ipc_cond_t cond;
    logic      hold;
    pc_t       target;
  } ipc_uword_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic bad_n;
    logic row_past;
    logic k_past;
    logic k_edge;
    logic last;
  } ipc_stat_t;

  localparam pc_t S_WAIT   = 4'd0;
  localparam pc_t S_CHKN   = 4'd1;
  localparam pc_t S_ROWCHK = 4'd2;
  localparam pc_t S_KCHK   = 4'd3;
  localparam pc_t S_KSET   = 4'd4;
  localparam pc_t S_FSUM   = 4'd5;
  localparam pc_t S_FDRAIN = 4'd6;
  localparam pc_t S_WRITE  = 4'd7;
  localparam pc_t S_RSINIT = 4'd8;
  localparam pc_t S_RSUM   = 4'd9;
  localparam pc_t S_RDRAIN = 4'd10;
  localparam pc_t S_PART   = 4'd11;
  localparam pc_t S_DONE   = 4'd12;

  function automatic ipc_uword_t ucode(pc_t pc);
    ipc_uword_t w;
    case (pc)
      S_WAIT:   w = '{OP_ACCEPT, C_IN_FIRE,  1'b1, S_CHKN};
      S_CHKN:   w = '{OP_CHKN,   C_BAD_N,    1'b0, S_DONE};
      S_ROWCHK: w = '{OP_ROWCHK, C_ROW_PAST, 1'b0, S_RSINIT};
      S_KCHK:   w = '{OP_KCHK,   C_K_PAST,   1'b0, S_ROWCHK};
      S_KSET:   w = '{OP_KSET,   C_K_EDGE,   1'b0, S_KCHK};
      S_FSUM:   w = '{OP_SUM,    C_LAST,     1'b1, S_FDRAIN};
      S_FDRAIN: w = '{OP_NOP,    C_NEVER,    1'b0, S_WAIT};
      S_WRITE:  w = '{OP_WRITE,  C_ALWAYS,   1'b0, S_KCHK};
      S_RSINIT: w = '{OP_RSINIT, C_NEVER,    1'b0, S_WAIT};
      S_RSUM:   w = '{OP_SUM,    C_LAST,     1'b1, S_RDRAIN};
      S_RDRAIN: w = '{OP_NOP,    C_NEVER,    1'b0, S_WAIT};
      S_PART:   w = '{OP_PART,   C_NEVER,    1'b0, S_WAIT};
      S_DONE:   w = '{OP_DONE,   C_OUT_FREE, 1'b1, S_WAIT};
      default:  w = '{OP_NOP,    C_ALWAYS,   1'b0, S_WAIT};
    endcase
    return w;
  endfunction

  // Entry of p(row, col) in the table.
  function automatic addr_t row_addr(cnt_t row, cnt_t col);
    return AW'(row) * AW'(ROW_LEN) + AW'(col);
  endfunction

  // Unsigned add that sticks at the all-ones value.
  function automatic word_t sat_add(word_t a, word_t b);
    logic [DW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DW] ? ALL_ONES : s[DW-1:0];
  endfunction

endpackage

// ===== rtl/ipc_table.sv =====
// ----------------------------------------------------------------------------
// ipc_table
// Partition table with a write port and a registered read port: one write and one read per cycle.
// ----------------------------------------------------------------------------
module ipc_table
  import ipc_pkg::*;
(
  input  logic  clk,
  input  logic  wr_en,
  input  addr_t wr_addr,
  input  word_t wr_data,
  input  logic  rd_en,
  input  addr_t rd_addr,
  output word_t rd_data
);

  word_t mem [TABLE_DEPTH];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/ipc_seq.sv =====
// ----------------------------------------------------------------------------
// ipc_seq
// Step counter and control store: fetches one control word per cycle and
// branches on datapath status and the channel handshakes.
// ----------------------------------------------------------------------------
module ipc_seq
  import ipc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ipc_stat_t stat,
  input  logic      in_fire,
  input  logic      out_free,
  output ipc_op_t   op
);

  pc_t        pc_r;
  pc_t        pc_nxt;
  ipc_uword_t uw;
  logic       cond_true;

  assign uw = ucode(pc_r);
  assign op = uw.op;

  always_comb begin
    case (uw.cond)
      C_NEVER:    cond_true = 1'b0;
      C_ALWAYS:   cond_true = 1'b1;
      C_IN_FIRE:  cond_true = in_fire;
      C_BAD_N:    cond_true = stat.bad_n;
      C_ROW_PAST: cond_true = stat.row_past;
      C_K_PAST:   cond_true = stat.k_past;
      C_K_EDGE:   cond_true = stat.k_edge;
      C_LAST:     cond_true = stat.last;
      C_OUT_FREE: cond_true = out_free;
      default:    cond_true = 1'b0;
    endcase

    if (cond_true) begin
      pc_nxt = uw.target;
    end else if (uw.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/ipc_datapath.sv =====
// ----------------------------------------------------------------------------
// ipc_datapath
// Counters, saturating accumulator and partition table, driven by the
// operation code of the current control word.
// ----------------------------------------------------------------------------
module ipc_datapath
  import ipc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  ipc_op_t       op,
  input  logic          in_fire,
  input  logic [QW-1:0] query_n,
  input  logic [QW-1:0] query_k,
  output ipc_stat_t     stat,
  output word_t         part_val,
  output word_t         all_val,
  output logic          bad_req
);

  `include "integer_partition_counter_unit_macros.svh"

  cnt_t          n_r, n_nxt;
  logic [QW-1:0] k_r, k_nxt;
  cnt_t          r_r, r_nxt;
  cnt_t          kk_r, kk_nxt;
  cnt_t          i_r, i_nxt;
  cnt_t          m_r, m_nxt;
  cnt_t          top_r, top_nxt;
  cnt_t          rows_filled_r, rows_filled_nxt;
  logic          kval_r, kval_nxt;
  logic          acc_en_r, acc_en_nxt;
  word_t         acc_r, acc_nxt;
  cnt_t          m_diff;

  logic  wr_en;
  addr_t wr_addr;
  word_t wr_data;
  logic  rd_en;
  addr_t rd_addr;
  word_t rd_data;

  ipc_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign m_diff = r_r - kk_r;

  assign stat.bad_n    = (n_r == '0) || (n_r > CW'(MAX_N));
  assign stat.row_past = r_r > n_r;
  assign stat.k_past   = kk_r > r_r;
  assign stat.k_edge   = (kk_r == CW'(1)) || (kk_r == r_r);
  assign stat.last     = i_r == top_r;

  assign part_val = kval_r ? rd_data : '0;
  assign all_val  = acc_r;
  // The request is bad exactly when it has no valid (n, k) pair.
  assign bad_req  = !kval_r;

  always_comb begin
    n_nxt           = n_r;
    k_nxt           = k_r;
    r_nxt           = r_r;
    kk_nxt          = kk_r;
    i_nxt           = i_r;
    m_nxt           = m_r;
    top_nxt         = top_r;
    rows_filled_nxt = rows_filled_r;
    kval_nxt        = kval_r;
    acc_en_nxt      = (op == OP_SUM);
    acc_nxt         = acc_en_r ? sat_add(acc_r, rd_data) : acc_r;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;
    rd_en           = 1'b0;
    rd_addr         = '0;

    case (op)
      OP_ACCEPT: begin
        if (in_fire) begin
          n_nxt   = CW'(query_n);
          k_nxt   = query_k;
          r_nxt   = rows_filled_r + 1'b1;
          acc_nxt = '0;
        end
      end
      OP_CHKN: begin
        kval_nxt = !stat.bad_n && (k_r != '0) && (CW'(k_r) <= n_r);
      end
      OP_ROWCHK: begin
        kk_nxt = CW'(1);
      end
      OP_KCHK: begin
        if (stat.k_past) begin
          rows_filled_nxt = r_r;
          r_nxt           = r_r + 1'b1;
        end
      end
      OP_KSET: begin
        if (stat.k_edge) begin
          wr_en   = 1'b1;
          wr_addr = row_addr(r_r, kk_r);
          wr_data = word_t'(1);
          kk_nxt  = kk_r + 1'b1;
        end else begin
          m_nxt   = m_diff;
          top_nxt = (m_diff < kk_r) ? m_diff : kk_r;
          i_nxt   = CW'(1);
          acc_nxt = '0;
        end
      end
      OP_SUM: begin
        rd_en   = 1'b1;
        rd_addr = row_addr(m_r, i_r);
        i_nxt   = i_r + 1'b1;
      end
      OP_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = row_addr(r_r, kk_r);
        wr_data = acc_r;
        kk_nxt  = kk_r + 1'b1;
      end
      OP_RSINIT: begin
        m_nxt   = n_r;
        top_nxt = n_r;
        i_nxt   = CW'(1);
        acc_nxt = '0;
      end
      OP_PART: begin
        if (kval_r) begin
          rd_en   = 1'b1;
          rd_addr = row_addr(n_r, CW'(k_r));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_filled_r <= '0;
      acc_en_r      <= 1'b0;
    end else begin
      rows_filled_r <= rows_filled_nxt;
      acc_en_r      <= acc_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    r_r    <= r_nxt;
    kk_r   <= kk_nxt;
    i_r    <= i_nxt;
    m_r    <= m_nxt;
    top_r  <= top_nxt;
    kval_r <= kval_nxt;
    acc_r  <= acc_nxt;
  end

  // The filled region only ever grows.
  `IPC_ASSERT_NEXT(a_rows_grow, 1'b1, rows_filled_r >= $past(rows_filled_r), "rows shrank")
  // The filled region never passes the last row of the table.
  `IPC_ASSERT_SAME(a_rows_max, 1'b1, rows_filled_r <= CW'(MAX_N), "rows past table")
  // Every summed read hits a nonzero column of a row that is already filled.
  `IPC_ASSERT_SAME(a_read_filled, op == OP_SUM,
    (m_r != '0) && (m_r <= rows_filled_r) && (i_r != '0) && (i_r <= m_r),
    "read of unfilled entry")
  // Writes go only to the row right after the filled region.
  `IPC_ASSERT_SAME(a_write_row, wr_en, r_r == rows_filled_r + 1'b1, "write outside next row")

endmodule

// ===== rtl/integer_partition_counter_unit.sv =====
// ----------------------------------------------------------------------------
// integer_partition_counter_unit
// Answers p(n,k) and p(n) for a query (n, k) from a table of partition counts
// that is filled row by row on demand by a microcoded sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Ports                            | Contents
//  --------+-----------+----------------------------------+-----------------------
//  in_     | input     | in_tvalid/in_tready/in_tdata     | query_n, query_k
//  out_    | output    | out_tvalid/out_tready/out_tdata  | part_count, all_count,
//          |           | out_tuser                        | bad_request, saturated
//
//  A request whose row n is already built makes one pass over row n through
//  the single table read port to sum p(n), then one more read fetches p(n,k).
//  A request with n of zero goes from the n check straight to the done step.
//  Each new row r is built once for the life of the block: its edge entries
//  are written as one, and each inner entry is summed through the same port.
//  Reset clears the filled-row count and the control state only; the table
//  needs no clearing pass because an entry is read only after it is written.
//  One request is worked on at a time. A finished result waits in the output
//  register, and the next request is taken while it waits; the sequencer only
//  stalls when a second result is ready before the first has left.
//
module integer_partition_counter_unit
  import ipc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,    // [6:0] query_n, [13:7] query_k, [15:14] zero
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,   // [63:0] part_count, [127:64] all_count
  output logic [1:0]   out_tuser    // [0] bad_request, [1] saturated
);

  ipc_op_t   op;
  ipc_stat_t stat;
  logic      in_fire;
  logic      out_free;
  word_t     part_val;
  word_t     all_val;
  logic      bad_req;

  logic      out_valid_r;
  word_t     part_count_r;
  word_t     all_count_r;
  logic      bad_request_r;
  logic      saturated_r;

  // The sequencer offers a request slot only in its wait step.
  assign in_tready = (op == OP_ACCEPT);
  assign in_fire   = in_tvalid && in_tready;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || out_tready;

  ipc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .in_fire  (in_fire),
    .out_free (out_free),
    .op       (op)
  );

  ipc_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .in_fire  (in_fire),
    .query_n  (in_tdata[6:0]),
    .query_k  (in_tdata[13:7]),
    .stat     (stat),
    .part_val (part_val),
    .all_val  (all_val),
    .bad_req  (bad_req)
  );

  // Result register: loaded in the done step when the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((op == OP_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // A request is bad when n is zero or k is zero or above n; the datapath
  // then forces part_val to zero.
  always_ff @(posedge clk) begin
    if ((op == OP_DONE) && out_free) begin
      part_count_r  <= part_val;
      all_count_r   <= all_val;
      bad_request_r <= bad_req;
      saturated_r   <= (part_val == ALL_ONES) || (all_val == ALL_ONES);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {all_count_r, part_count_r};
  assign out_tuser  = {saturated_r, bad_request_r};

endmodule
